/* design/mst_pkg.sv */
// shared constants, types and codes for the marching squares contour tracer
`default_nettype none

package mst_pkg;

  // image geometry limits
  localparam int MAX_WIDTH  = 256;
  localparam int MAX_HEIGHT = 256;
  localparam int XB         = $clog2(MAX_WIDTH);
  localparam int YB         = $clog2(MAX_HEIGHT);
  localparam int ADDR_W     = XB + YB;
  localparam int MAP_DEPTH  = MAX_WIDTH * MAX_HEIGHT;
  localparam int COORD_W    = 9;

  // configuration register indexes
  localparam logic REG_WIDTH  = 1'b0;
  localparam logic REG_HEIGHT = 1'b1;

  // operation codes
  localparam logic [1:0] OP_LOAD  = 2'd0;
  localparam logic [1:0] OP_BEGIN = 2'd1;
  localparam logic [1:0] OP_ADV   = 2'd2;

  typedef logic [COORD_W-1:0] coord_t;
  typedef logic [2:0] dir_t;

  // trace directions
  localparam dir_t DIR_NONE  = 3'd0;
  localparam dir_t DIR_UP    = 3'd1;
  localparam dir_t DIR_LEFT  = 3'd2;
  localparam dir_t DIR_DOWN  = 3'd3;
  localparam dir_t DIR_RIGHT = 3'd4;

  // outcome of one trace step
  typedef struct packed {
    dir_t   dir;
    coord_t nx;
    coord_t ny;
    logic   stuck;
  } step_t;

endpackage

`default_nettype wire

/* design/marching_squares_contour_tracer.sv */
// top level of the marching squares contour tracer with its solid map memory
//
//  channel | dir | handshake          | contents
//  --------+-----+--------------------+------------------------------------------
//  in_     | in  | tvalid/tready      | tuser operation, tdata pixel x/y/value
//  out_    | out | tvalid/tready      | tdata point/flags, tlast back at start
//  cfg_    | in  | we                 | addr 0 width, 1 height, wdata value
//
// loads can follow each other every cycle while the tracer is idle
// an advance reads the four neighbours on the one map read port, each captured in the
// cycle after its read, then registers the result and returns to idle
// a begin scans in raster order up to the first solid pixel, or the whole image when none is solid
// reset clears control state only; the map holds nothing until loaded
// a waiting result keeps input open; the next begin or advance holds its result until it drains
`default_nettype none

module marching_squares_contour_tracer
  import mst_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  // config write port
  input  wire logic        cfg_we,
  input  wire logic        cfg_addr,
  input  wire logic [8:0]  cfg_wdata,
  // input stream
  input  wire logic        in_tvalid,
  output      logic        in_tready,
  input  wire logic [23:0] in_tdata,   // pixel_x[7:0], pixel_y[15:8], pixel_value[23:16]
  input  wire logic [1:0]  in_tuser,   // operation[1:0]
  // output stream
  output      logic        out_tvalid,
  input  wire logic        out_tready,
  output      logic [23:0] out_tdata,  // point_x[8:0], point_y_flipped[17:9],
                                       // point_valid[18], found[19], stuck[20], zero
  output      logic        out_tlast
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_ADV  = 2'd1;
  localparam logic [1:0] S_SCAN = 2'd2;
  localparam logic [1:0] S_FIN  = 2'd3;

  logic [1:0]  state_r, state_nxt;
  logic [8:0]  cfg_w_r, cfg_h_r;
  coord_t      eff_w, eff_h;
  logic        op_adv_r;
  coord_t      cur_x_r, cur_y_r, start_x_r, start_y_r;
  dir_t        next_dir_r;
  logic        found_r;
  logic [2:0]  adv_cnt_r;
  logic [3:0]  sq_r;
  logic        nb_in_r;
  coord_t      nb_x, nb_y;
  logic        nb_in;
  coord_t      scan_x_r, scan_y_r;
  logic        scan_done_r;
  logic        chk_vld_r;
  coord_t      chk_x_r, chk_y_r;
  logic        scan_hit;
  logic        scan_miss;
  logic        in_xfer;
  logic        out_free;
  logic        fin_fire;
  logic        cur_inside;
  step_t       step;

  logic               map_mem [MAP_DEPTH];
  logic [ADDR_W-1:0]  rd_addr;
  logic               rd_data_r;

  // out of range sizes clamp to one and to the maximum
  always_comb begin
    eff_w = cfg_w_r;
    if (cfg_w_r == 9'd0) eff_w = coord_t'(1);
    else if (cfg_w_r > coord_t'(MAX_WIDTH)) eff_w = coord_t'(MAX_WIDTH);
    eff_h = cfg_h_r;
    if (cfg_h_r == 9'd0) eff_h = coord_t'(1);
    else if (cfg_h_r > coord_t'(MAX_HEIGHT)) eff_h = coord_t'(MAX_HEIGHT);
  end

  assign in_tready = (state_r == S_IDLE);
  assign in_xfer   = in_tvalid && in_tready;
  assign out_free  = !out_tvalid || out_tready;
  assign fin_fire  = (state_r == S_FIN) && out_free;

  // neighbour for this read: bit0 of the count picks right column, bit1 lower row
  assign nb_x  = adv_cnt_r[0] ? cur_x_r : cur_x_r - coord_t'(1);
  assign nb_y  = adv_cnt_r[1] ? cur_y_r : cur_y_r - coord_t'(1);
  assign nb_in = (nb_x < eff_w) && (nb_y < eff_h);

  // scan end detection
  assign scan_hit  = chk_vld_r && rd_data_r;
  assign scan_miss = scan_done_r && !chk_vld_r;

  assign cur_inside = (cur_x_r < eff_w) && (cur_y_r < eff_h);

  mst_dir u_dir (
    .sq       (sq_r),
    .prev_dir (next_dir_r),
    .cur_x    (cur_x_r),
    .cur_y    (cur_y_r),
    .step     (step)
  );

  // map read address
  always_comb begin
    if (state_r == S_SCAN) begin
      rd_addr = {scan_y_r[YB-1:0], scan_x_r[XB-1:0]};
    end else begin
      rd_addr = {nb_y[YB-1:0], nb_x[XB-1:0]};
    end
  end

  // solid map: one write port for loads, one registered read port
  always_ff @(posedge clk) begin
    if (in_xfer && in_tuser == OP_LOAD) begin
      map_mem[{in_tdata[8 +: YB], in_tdata[0 +: XB]}] <= (in_tdata[23:16] != 8'd0);
    end
    rd_data_r <= map_mem[rd_addr];
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_IDLE: begin
        if (in_xfer && in_tuser == OP_BEGIN) state_nxt = S_SCAN;
        else if (in_xfer && in_tuser == OP_ADV) state_nxt = S_ADV;
      end
      S_ADV: begin
        if (adv_cnt_r == 3'd4) state_nxt = S_FIN;
      end
      S_SCAN: begin
        if (scan_hit || scan_miss) state_nxt = S_FIN;
      end
      S_FIN: begin
        if (out_free) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  // control and trace state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cfg_w_r     <= 9'd256;
      cfg_h_r     <= 9'd256;
      op_adv_r    <= 1'b0;
      cur_x_r     <= '0;
      cur_y_r     <= '0;
      start_x_r   <= '0;
      start_y_r   <= '0;
      next_dir_r  <= DIR_NONE;
      found_r     <= 1'b0;
      adv_cnt_r   <= '0;
      scan_done_r <= 1'b0;
      chk_vld_r   <= 1'b0;
      out_tvalid  <= 1'b0;
    end else begin
      state_r <= state_nxt;

      // register writes
      if (cfg_we) begin
        if (cfg_addr == REG_WIDTH) cfg_w_r <= cfg_wdata;
        else cfg_h_r <= cfg_wdata;
      end

      // result handshake
      if (fin_fire) out_tvalid <= 1'b1;
      else if (out_tvalid && out_tready) out_tvalid <= 1'b0;

      case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            op_adv_r    <= (in_tuser == OP_ADV);
            adv_cnt_r   <= '0;
            scan_x_r    <= '0;
            scan_y_r    <= '0;
            scan_done_r <= 1'b0;
            chk_vld_r   <= 1'b0;
          end
        end
        // four neighbour reads, each captured in the following cycle
        S_ADV: begin
          nb_in_r   <= nb_in;
          adv_cnt_r <= adv_cnt_r + 3'd1;
          if (adv_cnt_r != 3'd0) sq_r <= {rd_data_r && nb_in_r, sq_r[3:1]};
        end
        // raster scan, one map bit a cycle
        S_SCAN: begin
          chk_vld_r <= !scan_done_r;
          chk_x_r   <= scan_x_r;
          chk_y_r   <= scan_y_r;
          if (!scan_done_r) begin
            if (scan_x_r == eff_w - coord_t'(1)) begin
              scan_x_r <= '0;
              scan_y_r <= scan_y_r + coord_t'(1);
              if (scan_y_r == eff_h - coord_t'(1)) scan_done_r <= 1'b1;
            end else begin
              scan_x_r <= scan_x_r + coord_t'(1);
            end
          end
          if (scan_hit) begin
            start_x_r  <= chk_x_r;
            start_y_r  <= chk_y_r;
            cur_x_r    <= chk_x_r;
            cur_y_r    <= chk_y_r;
            found_r    <= 1'b1;
            next_dir_r <= DIR_NONE;
          end else if (scan_miss) begin
            start_x_r  <= '0;
            start_y_r  <= '0;
            cur_x_r    <= '0;
            cur_y_r    <= '0;
            found_r    <= 1'b0;
            next_dir_r <= DIR_NONE;
          end
        end
        // corner update
        S_FIN: begin
          if (out_free) begin
            if (op_adv_r) begin
              cur_x_r    <= step.nx;
              cur_y_r    <= step.ny;
              next_dir_r <= step.dir;
            end
          end
        end
        default: ;
      endcase
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (fin_fire) begin
      out_tdata[23:21] <= 3'd0;
      if (op_adv_r) begin
        out_tdata[8:0]  <= cur_inside ? cur_x_r : '0;
        out_tdata[17:9] <= cur_inside ? eff_h - cur_y_r : '0;
        out_tdata[18]   <= cur_inside;
        out_tdata[19]   <= 1'b0;
        out_tdata[20]   <= step.stuck;
        out_tlast       <= (step.nx == start_x_r) && (step.ny == start_y_r);
      end else begin
        out_tdata[8:0]  <= start_x_r;
        out_tdata[17:9] <= eff_h - start_y_r;
        out_tdata[18]   <= 1'b0;
        out_tdata[19]   <= found_r;
        out_tdata[20]   <= 1'b0;
        out_tlast       <= 1'b0;
      end
    end
  end

  // checks
  a_adv_cnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_ADV) |-> (adv_cnt_r <= 3'd4))
    else $error("advance read count out of range");

  a_hit_ends_scan: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SCAN && scan_hit) |=> (state_r == S_FIN))
    else $error("scan hit did not end the scan");

  a_result_from_fin: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_tvalid) |-> ($past(state_r) == S_FIN))
    else $error("result raised outside the result state");

  a_stuck_holds: assert property (@(posedge clk) disable iff (!rst_n)
    (fin_fire && op_adv_r && step.stuck) |=> ($stable(cur_x_r) && $stable(cur_y_r)))
    else $error("corner moved on a stuck step");

  a_corner_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (cur_x_r <= coord_t'(MAX_WIDTH)) && (cur_y_r <= coord_t'(MAX_HEIGHT)))
    else $error("corner left the image frame");

endmodule

`default_nettype wire

/* design/mst_dir.sv */
// marching squares direction decode and corner move
`default_nettype none

module mst_dir
  import mst_pkg::*;
(
  input  wire logic [3:0] sq,        // ul=bit0, ur=bit1, dl=bit2, dr=bit3
  input  wire dir_t       prev_dir,
  input  wire coord_t     cur_x,
  input  wire coord_t     cur_y,
  output step_t           step
);

  dir_t d;

  // direction from the 2x2 pattern, ambiguous saddles use the previous step
  always_comb begin
    case (sq)
      4'd1, 4'd5, 4'd13: d = DIR_UP;
      4'd2, 4'd3, 4'd7:  d = DIR_RIGHT;
      4'd4, 4'd12, 4'd14: d = DIR_LEFT;
      4'd8, 4'd10, 4'd11: d = DIR_DOWN;
      4'd6:  d = (prev_dir == DIR_UP) ? DIR_LEFT : DIR_RIGHT;
      4'd9:  d = (prev_dir == DIR_RIGHT) ? DIR_UP : DIR_DOWN;
      default: d = DIR_NONE;
    endcase
  end

  // move one corner
  always_comb begin
    step.dir   = d;
    step.nx    = cur_x;
    step.ny    = cur_y;
    step.stuck = 1'b0;
    case (d)
      DIR_UP:    step.ny = cur_y - coord_t'(1);
      DIR_LEFT:  step.nx = cur_x - coord_t'(1);
      DIR_DOWN:  step.ny = cur_y + coord_t'(1);
      DIR_RIGHT: step.nx = cur_x + coord_t'(1);
      default:   step.stuck = 1'b1;
    endcase
  end

endmodule

`default_nettype wire

/* verif/marching_squares_contour_tracer_tb.sv */
// self-checking testbench for the marching squares contour tracer
`default_nettype none

module marching_squares_contour_tracer_tb
  import mst_pkg::*;
();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int CLK_PERIOD  = 20;
  localparam int RAND_ITEMS  = 750;
  localparam int SETTLE      = 16;
  // limit kept well above the slowest legal run (scans, stalls and gaps included)
  localparam int CYCLE_LIMIT = 600000;

  // operation code the block leaves unused
  localparam logic [1:0] OP_NOP = 2'd3;

  // neighbour bits of the 2x2 window around a corner
  localparam logic [3:0] ST_UL = 4'd1;
  localparam logic [3:0] ST_UR = 4'd2;
  localparam logic [3:0] ST_DL = 4'd4;
  localparam logic [3:0] ST_DR = 4'd8;

  typedef struct packed {
    logic [1:0] op;
    logic [7:0] px;
    logic [7:0] py;
    logic [7:0] val;
  } pixel_cmd_t;

  typedef struct packed {
    logic [8:0] px;
    logic [8:0] py;
    logic       pv;
    logic       found;
    logic       stuck;
    logic       last;
  } point_rec_t;

  logic        clk        = 1'b0;
  logic        rst_n      = 1'b0;
  logic        cfg_we     = 1'b0;
  logic        cfg_addr   = 1'b0;
  logic [8:0]  cfg_wdata  = '0;
  logic        in_tvalid  = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata   = '0;
  logic [1:0]  in_tuser   = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [23:0] out_tdata;
  logic        out_tlast;

  // pending input items and expected results
  pixel_cmd_t cmd_q[$];
  point_rec_t point_q[$];
  int cmd_issued   = 0;
  int cmd_taken    = 0;
  int work_items   = 0;
  int err_cnt      = 0;
  int cycle_cnt    = 0;
  int in_idle_max  = 0;
  int out_idle_max = 0;
  int in_gap       = 0;
  int out_gap      = 0;
  logic in_took    = 1'b0;
  logic out_took   = 1'b0;

  // predictor state
  bit          solid_mem [MAP_DEPTH];
  logic [8:0]  width_reg  = 9'd256;
  logic [8:0]  height_reg = 9'd256;
  logic [15:0] trace_x  = '0;
  logic [15:0] trace_y  = '0;
  logic [15:0] origin_x = '0;
  logic [15:0] origin_y = '0;
  dir_t        came_dir = DIR_NONE;
  dir_t        heading  = DIR_NONE;

  marching_squares_contour_tracer uut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // zero acts as one, anything above the maximum acts as the maximum
  function automatic int eff_dim(input logic [8:0] raw, input int cap);
    if (raw == 9'd0) return 1;
    if (int'(raw) > cap) return cap;
    return int'(raw);
  endfunction

  function automatic bit pix_solid(input logic [15:0] x, input logic [15:0] y,
                                   input int ew, input int eh);
    if (int'(x) >= ew || int'(y) >= eh) return 1'b0;
    return solid_mem[int'(y) * MAX_WIDTH + int'(x)];
  endfunction

  function automatic int pix_val(input int dens);
    return ($urandom_range(0, 99) < dens) ? $urandom_range(1, 255) : 0;
  endfunction

  function automatic int pick_idle();
    return ($urandom_range(0, 2) == 0) ? 0 : 7;
  endfunction

  function automatic int pick_dim();
    return ($urandom_range(0, 5) == 0) ? $urandom_range(7, 16) : $urandom_range(1, 6);
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    err_cnt++;
    if (err_cnt <= 100)
      $display("[%0t] %s mismatch: got %0d, expected %0d", $time, what, got, want);
  endtask

  task automatic send(input logic [1:0] op, input int x, input int y, input int v);
    pixel_cmd_t c;
    c.op  = op;
    c.px  = 8'(x);
    c.py  = 8'(y);
    c.val = 8'(v);
    cmd_q.insert(cmd_q.size(), c);
    cmd_issued++;
    if (op != OP_NOP) work_items++;
  endtask

  // block is idle: every item taken, every result seen, then a short settle
  task automatic wait_idle();
    @(negedge clk);
    while (cmd_taken != cmd_issued || point_q.size() != 0) @(negedge clk);
    repeat (SETTLE) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [8:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    if (idx == REG_WIDTH) width_reg = val;
    else height_reg = val;
  endtask

  // input driver: one item at a time, random gap after each
  always @(negedge clk) begin : feeder
    pixel_cmd_t c;
    if (!rst_n) begin
      in_tvalid <= 1'b0;
    end else if (in_tvalid && !in_took) begin
      // hold the item until the transfer
    end else if (in_gap > 0) begin
      in_tvalid <= 1'b0;
      in_gap--;
    end else if (cmd_q.size() != 0) begin
      c = cmd_q.pop_front();
      in_tuser  <= c.op;
      in_tdata  <= {c.val, c.py, c.px};
      in_tvalid <= 1'b1;
      in_gap = $urandom_range(0, in_idle_max);
    end else begin
      in_tvalid <= 1'b0;
    end
  end

  // result side backpressure: random stall after each transfer
  always @(negedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_took) out_gap = $urandom_range(0, out_idle_max);
      if (out_gap > 0) begin
        out_tready <= 1'b0;
        out_gap--;
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  // monitor: check results, then predict from accepted items
  always @(posedge clk) begin : monitor
    point_rec_t  want;
    point_rec_t  r;
    logic [15:0] xl;
    logic [15:0] yu;
    logic [3:0]  nb;
    dir_t        d;
    int          ew;
    int          eh;
    bit          hit;
    in_took  <= rst_n && in_tvalid && in_tready;
    out_took <= rst_n && out_tvalid && out_tready;

    // a result always belongs to an item taken in an earlier cycle
    if (rst_n && out_tvalid && out_tready) begin
      if (point_q.size() == 0) begin
        report_mismatch("unexpected result", 1, 0);
      end else begin
        want = point_q.pop_front();
        if (out_tdata[8:0] !== want.px)
          report_mismatch("point_x", int'(out_tdata[8:0]), int'(want.px));
        if (out_tdata[17:9] !== want.py)
          report_mismatch("point_y_flipped", int'(out_tdata[17:9]), int'(want.py));
        if (out_tdata[18] !== want.pv)
          report_mismatch("point_valid", int'(out_tdata[18]), int'(want.pv));
        if (out_tdata[19] !== want.found)
          report_mismatch("found", int'(out_tdata[19]), int'(want.found));
        if (out_tdata[20] !== want.stuck)
          report_mismatch("stuck", int'(out_tdata[20]), int'(want.stuck));
        if (out_tdata[23:21] !== 3'd0)
          report_mismatch("tdata padding", int'(out_tdata[23:21]), 0);
        if (out_tlast !== want.last)
          report_mismatch("last", int'(out_tlast), int'(want.last));
      end
    end

    if (rst_n && in_tvalid && in_tready) begin
      cmd_taken++;
      ew = eff_dim(width_reg, MAX_WIDTH);
      eh = eff_dim(height_reg, MAX_HEIGHT);
      r  = '0;
      case (in_tuser)
        OP_LOAD: begin
          solid_mem[int'(in_tdata[15:8]) * MAX_WIDTH + int'(in_tdata[7:0])] =
            (in_tdata[23:16] != 8'd0);
        end
        OP_BEGIN: begin
          // raster scan for the first solid pixel
          hit = 1'b0;
          origin_x = '0;
          origin_y = '0;
          for (int yy = 0; yy < eh && !hit; yy++) begin
            for (int xx = 0; xx < ew && !hit; xx++) begin
              if (solid_mem[yy * MAX_WIDTH + xx]) begin
                origin_x = 16'(xx);
                origin_y = 16'(yy);
                hit = 1'b1;
              end
            end
          end
          trace_x  = origin_x;
          trace_y  = origin_y;
          came_dir = DIR_NONE;
          heading  = DIR_NONE;
          r.px     = origin_x[8:0];
          r.py     = 9'(eh - int'(origin_y));
          r.found  = hit;
          point_q.insert(point_q.size(), r);
        end
        OP_ADV: begin
          xl = trace_x - 16'd1;
          yu = trace_y - 16'd1;
          nb = '0;
          if (pix_solid(xl, yu, ew, eh)) nb |= ST_UL;
          if (pix_solid(trace_x, yu, ew, eh)) nb |= ST_UR;
          if (pix_solid(xl, trace_y, ew, eh)) nb |= ST_DL;
          if (pix_solid(trace_x, trace_y, ew, eh)) nb |= ST_DR;
          came_dir = heading;
          case (nb)
            ST_UL, ST_UL | ST_DL, ST_UL | ST_DL | ST_DR:         d = DIR_UP;
            ST_UR, ST_UL | ST_UR, ST_UL | ST_UR | ST_DL:         d = DIR_RIGHT;
            ST_DL, ST_DL | ST_DR, ST_UR | ST_DL | ST_DR:         d = DIR_LEFT;
            ST_DR, ST_UR | ST_DR, ST_UL | ST_UR | ST_DR:         d = DIR_DOWN;
            // saddles resolved by the direction we came from
            ST_UR | ST_DL: d = (came_dir == DIR_UP) ? DIR_LEFT : DIR_RIGHT;
            ST_UL | ST_DR: d = (came_dir == DIR_RIGHT) ? DIR_UP : DIR_DOWN;
            default:       d = DIR_NONE;
          endcase
          heading = d;
          // emit the corner only when inside the image
          if (int'(trace_x) < ew && int'(trace_y) < eh) begin
            r.px = trace_x[8:0];
            r.py = 9'(eh - int'(trace_y));
            r.pv = 1'b1;
          end
          case (d)
            DIR_UP:    trace_y = trace_y - 16'd1;
            DIR_LEFT:  trace_x = trace_x - 16'd1;
            DIR_DOWN:  trace_y = trace_y + 16'd1;
            DIR_RIGHT: trace_x = trace_x + 16'd1;
            default:   r.stuck = 1'b1;
          endcase
          r.last = (trace_x == origin_x && trace_y == origin_y);
          point_q.insert(point_q.size(), r);
        end
        default: ; // unused code, no effect
      endcase
    end
  end

  // watchdog
  always @(posedge clk) begin
    cycle_cnt <= cycle_cnt + 1;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  initial begin : stimulus
    int w;
    int h;
    int dens;
    int fx;
    int steps;
    int sel;
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    repeat (3) @(negedge clk);

    // directed: empty image, single pixel loop, full window, saddle
    write_reg(REG_WIDTH, 9'd2);
    write_reg(REG_HEIGHT, 9'd2);
    in_idle_max  = pick_idle();
    out_idle_max = pick_idle();
    @(posedge clk);
    send(OP_LOAD, 255, 255, 255);
    for (int yy = 0; yy < 2; yy++)
      for (int xx = 0; xx < 2; xx++) send(OP_LOAD, xx, yy, 0);
    send(OP_NOP, 255, 255, 255);
    send(OP_BEGIN, 0, 0, 0);
    send(OP_ADV, 255, 255, 255);
    send(OP_LOAD, 1, 1, 128);
    send(OP_BEGIN, $urandom_range(0, 255), $urandom_range(0, 255), $urandom_range(0, 255));
    repeat (4) send(OP_ADV, $urandom_range(0, 255), $urandom_range(0, 255), 0);
    // fill the window around the current corner so nothing can move
    send(OP_LOAD, 0, 0, 1);
    send(OP_LOAD, 1, 0, 2);
    send(OP_LOAD, 0, 1, 64);
    send(OP_ADV, 0, 0, 0);
    // diagonal pair: saddle on the way round
    send(OP_LOAD, 1, 0, 0);
    send(OP_LOAD, 0, 1, 0);
    send(OP_BEGIN, 0, 0, 0);
    repeat (4) send(OP_ADV, 0, 0, 0);
    wait_idle();

    // widest image, one row; width above the maximum
    write_reg(REG_WIDTH, 9'd511);
    write_reg(REG_HEIGHT, 9'd1);
    in_idle_max  = pick_idle();
    out_idle_max = pick_idle();
    fx = $urandom_range(0, 255);
    @(posedge clk);
    for (int xx = 0; xx < 256; xx++)
      send(OP_LOAD, xx, 0, (xx == fx) ? $urandom_range(1, 255) : pix_val(12));
    send(OP_BEGIN, 0, 0, 0);
    repeat (24) send(OP_ADV, 0, 0, 0);
    wait_idle();

    // height above the maximum; row 0 holds a solid pixel, row 1 stays clear
    write_reg(REG_WIDTH, 9'd8);
    write_reg(REG_HEIGHT, 9'd300);
    in_idle_max  = pick_idle();
    out_idle_max = pick_idle();
    @(posedge clk);
    send(OP_LOAD, $urandom_range(0, 7), 0, $urandom_range(1, 255));
    for (int xx = 0; xx < 8; xx++) send(OP_LOAD, xx, 1, 0);
    send(OP_BEGIN, 0, 0, 0);
    repeat (30) send(OP_ADV, 0, 0, 0);
    wait_idle();

    // one column; zero width acts as one
    write_reg(REG_WIDTH, 9'd0);
    write_reg(REG_HEIGHT, 9'd48);
    in_idle_max  = pick_idle();
    out_idle_max = pick_idle();
    @(posedge clk);
    for (int yy = 2; yy < 48; yy++) send(OP_LOAD, 0, yy, pix_val(25));
    send(OP_BEGIN, 0, 0, 0);
    repeat (30) send(OP_ADV, 0, 0, 0);
    wait_idle();

    // random small images: load the whole image, then trace
    while (work_items < RAND_ITEMS) begin
      w = pick_dim();
      h = pick_dim();
      write_reg(REG_WIDTH, (w == 1 && $urandom_range(0, 3) == 0) ? 9'd0 : 9'(w));
      write_reg(REG_HEIGHT, (h == 1 && $urandom_range(0, 3) == 0) ? 9'd0 : 9'(h));
      in_idle_max  = pick_idle();
      out_idle_max = pick_idle();
      dens = $urandom_range(15, 85);
      @(posedge clk);
      for (int yy = 0; yy < h; yy++)
        for (int xx = 0; xx < w; xx++) send(OP_LOAD, xx, yy, pix_val(dens));
      // most runs restart the trace, some carry on from the old corner
      if ($urandom_range(0, 4) != 0)
        send(OP_BEGIN, $urandom_range(0, 255), $urandom_range(0, 255),
             $urandom_range(0, 255));
      steps = $urandom_range(6, 40);
      repeat (steps) begin
        sel = $urandom_range(0, 15);
        if (sel == 0)
          send(OP_NOP, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255));
        else if (sel == 1)
          send(OP_LOAD, $urandom_range(0, w - 1), $urandom_range(0, h - 1), pix_val(dens));
        else
          send(OP_ADV, $urandom_range(0, 255), $urandom_range(0, 255),
               $urandom_range(0, 255));
      end
      wait_idle();
    end

    wait_idle();
    if (err_cnt == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

`default_nettype wire
